@@ hdl/sitoa_pkg.sv @@
// shared types, character codes and the bcd digit adjust for the decimal text unit
package sitoa_pkg;

  typedef logic [3:0] digit_t;
  typedef logic [5:0] code_t;

  localparam code_t CODE_MINUS = 6'd45;
  localparam code_t CODE_ZERO  = 6'd48;
  localparam digit_t DIGIT_MAX = 4'd9;

  // add-3 correction applied before each doubling of a bcd digit
  function automatic digit_t add3(input digit_t d);
    digit_t r;
    r = (d >= 4'd5) ? d + 4'd3 : d;
    return r;
  endfunction

endpackage

@@ hdl/sitoa_conv.sv @@
// iterative shift-add-3 binary to bcd converter that also shifts digits out
module sitoa_conv #(
  parameter int VALUE_BITS = 32,
  parameter int NDIG       = 10
) (
  input  logic                    clk,
  input  logic                    rst,
  input  logic                    start,
  input  logic [VALUE_BITS-1:0]   mag,
  input  logic                    shift_digit,
  output logic                    busy,
  output sitoa_pkg::digit_t       top_digit
);
  import sitoa_pkg::*;

  localparam int CW = $clog2(VALUE_BITS);
  localparam int BW = NDIG * 4;

  logic [BW-1:0]         bcd;
  logic [BW-1:0]         bcd_adj;
  logic [VALUE_BITS-1:0] mag_r;
  logic [CW-1:0]         cnt;

  always_comb begin
    for (int i = 0; i < NDIG; i++) begin
      bcd_adj[i*4 +: 4] = add3(bcd[i*4 +: 4]);
    end
  end

  assign top_digit = bcd[BW-1 -: 4];

  always_ff @(posedge clk) begin
    if (rst) begin
      busy <= 1'b0;
      cnt  <= '0;
    end else if (start) begin
      mag_r <= mag;
      bcd   <= '0;
      cnt   <= '0;
      busy  <= 1'b1;
    end else if (busy) begin
      {bcd, mag_r} <= {bcd_adj[BW-2:0], mag_r, 1'b0};
      cnt          <= cnt + 1'b1;
      if (cnt == CW'(VALUE_BITS - 1)) begin
        busy <= 1'b0;
      end
    end else if (shift_digit) begin
      bcd <= {bcd[BW-5:0], 4'd0};
    end
  end

endmodule

@@ hdl/signed_int_to_decimal_ascii_unit.sv @@
// signed integer to decimal ascii text, one character per output item
// sequence: shift-add-3 over every magnitude bit in the converter, then a done check, then the
//   leading zero digits are skipped one by one, a decision step, an optional minus sign, then one
//   character per cycle unless char_stall holds the output; a new value is not taken until the
//   last character of the previous one is out, and value_stall is high meanwhile
// reset: rst (synchronous) returns the sequencer to idle and drops char_valid
module signed_int_to_decimal_ascii_unit #(
  parameter int VALUE_BITS = 32
) (
  input  logic                         clk,
  input  logic                         rst,
  input  logic                         value_valid,
  output logic                         value_stall,
  input  logic signed [VALUE_BITS-1:0] value,
  output logic                         char_valid,
  input  logic                         char_stall,
  output sitoa_pkg::code_t             char_code,
  output logic                         last_char
);
  import sitoa_pkg::*;

  localparam int NDIG = (VALUE_BITS * 30103) / 100000 + 1;
  localparam int DW   = $clog2(NDIG + 1);

  localparam logic [2:0] S_IDLE = 3'd0;
  localparam logic [2:0] S_CONV = 3'd1;
  localparam logic [2:0] S_SKIP = 3'd2;
  localparam logic [2:0] S_SIGN = 3'd3;
  localparam logic [2:0] S_EMIT = 3'd4;

  logic [2:0]            state;
  logic                  neg;
  logic [DW-1:0]         dleft;
  logic                  accept;
  logic                  slot_free;
  logic                  emit;
  logic                  skip_zero;
  logic                  shift_digit;
  logic                  conv_busy;
  digit_t                top_digit;
  logic [VALUE_BITS-1:0] raw;
  logic [VALUE_BITS-1:0] mag_in;

  assign raw         = $unsigned(value);
  assign mag_in      = raw[VALUE_BITS-1] ? (~raw + 1'b1) : raw;
  assign value_stall = (state != S_IDLE);
  assign accept      = value_valid && !value_stall;
  assign slot_free   = !char_valid || !char_stall;
  assign emit        = ((state == S_SIGN) || (state == S_EMIT)) && slot_free;
  assign skip_zero   = (top_digit == 4'd0) && (dleft > DW'(1));
  assign shift_digit = ((state == S_SKIP) && skip_zero) || ((state == S_EMIT) && slot_free);

  sitoa_conv #(
    .VALUE_BITS(VALUE_BITS),
    .NDIG      (NDIG)
  ) u_conv (
    .clk        (clk),
    .rst        (rst),
    .start      (accept),
    .mag        (mag_in),
    .shift_digit(shift_digit),
    .busy       (conv_busy),
    .top_digit  (top_digit)
  );

  always_ff @(posedge clk) begin
    if (rst) begin
      state      <= S_IDLE;
      char_valid <= 1'b0;
      neg        <= 1'b0;
      dleft      <= '0;
    end else begin
      char_valid <= emit || (char_valid && char_stall);
      case (state)
        S_IDLE: begin
          if (accept) begin
            neg   <= raw[VALUE_BITS-1];
            dleft <= DW'(NDIG);
            state <= S_CONV;
          end
        end
        S_CONV: begin
          if (!conv_busy) begin
            state <= S_SKIP;
          end
        end
        S_SKIP: begin
          if (skip_zero) begin
            dleft <= dleft - 1'b1;
          end else begin
            state <= neg ? S_SIGN : S_EMIT;
          end
        end
        S_SIGN: begin
          if (slot_free) begin
            char_code  <= CODE_MINUS;
            last_char  <= 1'b0;
            state      <= S_EMIT;
          end
        end
        S_EMIT: begin
          if (slot_free) begin
            char_code  <= CODE_ZERO + {2'b00, top_digit};
            last_char  <= (dleft == DW'(1));
            dleft      <= dleft - 1'b1;
            if (dleft == DW'(1)) begin
              state <= S_IDLE;
            end
          end
        end
        default: begin
          state <= S_IDLE;
        end
      endcase
    end
  end

`ifndef NO_ASSERTIONS
  a_busy_after_accept: assert property (@(posedge clk) disable iff (rst)
    accept |=> value_stall)
    else $error("item accepted but block did not go busy");

  a_code_range: assert property (@(posedge clk) disable iff (rst)
    char_valid |-> (char_code == CODE_MINUS ||
                    (char_code >= CODE_ZERO && char_code <= CODE_ZERO + {2'b00, DIGIT_MAX})))
    else $error("character code out of range");

  a_minus_not_last: assert property (@(posedge clk) disable iff (rst)
    (char_valid && char_code == CODE_MINUS) |-> !last_char)
    else $error("minus sign flagged as last character");

  a_idle_conv_quiet: assert property (@(posedge clk) disable iff (rst)
    (state == S_IDLE || state == S_SKIP || state == S_EMIT) |-> !conv_busy)
    else $error("converter busy outside conversion");
`endif

endmodule

@@ tb/sitoa_checker.sv @@
// checker for the decimal text unit: predicts each character run and compares it
module sitoa_checker (
  input  logic             clk,
  input  logic             rst,
  input  logic             value_valid,
  input  logic             value_stall,
  input  logic [31:0]      value,
  input  logic             char_valid,
  input  logic             char_stall,
  input  sitoa_pkg::code_t char_code,
  input  logic             last_char,
  output int               mismatches,
  output int               chars_pending,
  output int               values_taken,
  output int               chars_checked
);
  timeunit 1ns;
  timeprecision 1ps;

  import sitoa_pkg::*;

  localparam logic [31:0] RADIX = 32'd10;

  typedef struct packed {
    code_t code;
    logic  last;
  } text_char_t;

  text_char_t text_q[$];

  function automatic void render_decimal(input logic [31:0] v);
    logic [31:0] mag;
    digit_t      digs[10];
    int          nd;
    mag = v[31] ? (~v + 32'd1) : v;
    nd = 0;
    do begin
      digs[nd] = digit_t'(mag % RADIX);
      mag = mag / RADIX;
      nd++;
    end while (mag != 0);
    if (v[31]) text_q.push_back('{code: CODE_MINUS, last: 1'b0});
    for (int i = nd - 1; i >= 0; i--)
      text_q.push_back('{code: code_t'(CODE_ZERO + code_t'(digs[i])), last: (i == 0)});
  endfunction

  always @(posedge clk) begin
    text_char_t want;
    if (rst) begin
      text_q.delete();
      mismatches = 0;
      values_taken = 0;
      chars_checked = 0;
    end else begin
      if (char_valid && !char_stall) begin
        if (text_q.size() == 0) begin
          $display("%0t: unexpected char item, code %0d last %b", $time, char_code, last_char);
          mismatches++;
        end else begin
          want = text_q.pop_front();
          chars_checked++;
          if (char_code !== want.code || last_char !== want.last) begin
            $display("%0t: mismatch, expected code %0d last %b, got code %0d last %b",
                     $time, want.code, want.last, char_code, last_char);
            mismatches++;
          end
        end
      end
      if (value_valid && !value_stall) begin
        render_decimal(value);
        values_taken++;
      end
    end
    chars_pending = text_q.size();
  end

endmodule

@@ tb/tb.sv @@
// testbench top for the decimal text unit: clock, reset, stimulus and verdict
module tb;
  timeunit 1ns;
  timeprecision 1ps;

  localparam int VALUE_BITS = 32;
  localparam int IDLE_LIMIT = 3000;
  localparam int HOLD_CYCLES = 300;
  localparam int QUIET_ITEMS = 30;
  localparam int NOISY_ITEMS = 70;

  logic                         clk = 1'b0;
  logic                         rst = 1'b1;
  logic                         value_valid = 1'b0;
  logic                         value_stall;
  logic signed [VALUE_BITS-1:0] value = '0;
  logic                         char_valid;
  logic                         char_stall = 1'b0;
  sitoa_pkg::code_t             char_code;
  logic                         last_char;

  int mismatches;
  int chars_pending;
  int values_taken;
  int chars_checked;
  int idle_cycles = 0;
  bit quiet = 1'b0;
  bit hold_req = 1'b0;

  logic [31:0] corner_values [20] = '{
    32'd0, 32'd1, 32'hFFFF_FFFF, 32'd9, 32'd10, -32'sd10, 32'd99, 32'd100,
    32'h7FFF_FFFF, 32'h8000_0000, 32'h8000_0001, 32'd1000000000, -32'sd1000000000,
    32'd999999999, 32'd123456789, 32'h5555_5555, 32'hAAAA_AAAA, 32'd7, -32'sd9,
    -32'sd1999999999
  };

  signed_int_to_decimal_ascii_unit #(.VALUE_BITS(VALUE_BITS)) dut (
    .clk(clk), .rst(rst),
    .value_valid(value_valid), .value_stall(value_stall), .value(value),
    .char_valid(char_valid), .char_stall(char_stall),
    .char_code(char_code), .last_char(last_char)
  );

  sitoa_checker u_checker (
    .clk(clk), .rst(rst),
    .value_valid(value_valid), .value_stall(value_stall), .value(value),
    .char_valid(char_valid), .char_stall(char_stall),
    .char_code(char_code), .last_char(last_char),
    .mismatches(mismatches), .chars_pending(chars_pending),
    .values_taken(values_taken), .chars_checked(chars_checked)
  );

  always #5 clk = ~clk;

  always @(posedge clk) begin
    if (rst || (value_valid && !value_stall) || (char_valid && !char_stall))
      idle_cycles <= 0;
    else
      idle_cycles <= idle_cycles + 1;
    if (idle_cycles >= IDLE_LIMIT) begin
      $display("%0t: no item moved for %0d cycles", $time, IDLE_LIMIT);
      $display("[FAIL] regression broken");
      $finish;
    end
  end

  // mostly numbers of a random digit count, the rest raw bit patterns
  function automatic logic [31:0] draw_integer();
    logic [31:0] mag;
    logic [31:0] lo;
    logic [31:0] hi;
    int          nd;
    if ($urandom_range(0, 9) < 4) return $urandom();
    nd = $urandom_range(1, 10);
    lo = (nd == 1) ? 32'd0 : 32'(10 ** (nd - 1));
    hi = (nd == 10) ? 32'h7FFF_FFFF : 32'(10 ** nd - 1);
    mag = $urandom_range(hi, lo);
    return $urandom_range(0, 1) ? -mag : mag;
  endfunction

  task automatic send_value(input logic [31:0] v);
    int gap;
    gap = quiet ? 0 : $urandom_range(0, 5);
    if (gap > 0) begin
      value_valid = 1'b0;
      repeat (gap) @(negedge clk);
    end
    value_valid = 1'b1;
    value = v;
    do @(posedge clk); while (value_stall);
    @(negedge clk);
  endtask

  // receiver: random hold-off per item outside the quiet phase, one long hold-off on request
  initial begin
    int n;
    @(negedge clk);
    while (rst) @(negedge clk);
    forever begin
      n = quiet ? 0 : $urandom_range(0, 5);
      if (hold_req) begin
        n = HOLD_CYCLES;
        hold_req = 1'b0;
      end
      if (n > 0) begin
        char_stall = 1'b1;
        repeat (n) @(negedge clk);
      end
      char_stall = 1'b0;
      do @(posedge clk); while (!char_valid);
      @(negedge clk);
    end
  end

  initial begin
    repeat (3) @(negedge clk);
    rst = 1'b0;

    foreach (corner_values[i]) send_value(corner_values[i]);

    quiet = 1'b1;
    repeat (QUIET_ITEMS) send_value(draw_integer());

    quiet = 1'b0;
    hold_req = 1'b1;
    repeat (NOISY_ITEMS) send_value(draw_integer());
    value_valid = 1'b0;

    while (chars_pending != 0) @(posedge clk);
    repeat (60) @(posedge clk);

    $display("covered %0d integers (zero, both extremes, every digit count, both signs)",
             values_taken);
    $display("checked %0d characters, %0d mismatches", chars_checked, mismatches);
    if (mismatches == 0)
      $display("[ OK ] regression clean");
    else
      $display("[FAIL] regression broken");
    $finish;
  end

endmodule
